[hdl/sfms_pkg.sv]
`default_nettype none

package sfms_pkg;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;

    localparam logic [3:0] CMD_OBS_LABEL  = 4'd0;
    localparam logic [3:0] CMD_OBS_FEAT   = 4'd1;
    localparam logic [3:0] CMD_OBS_END    = 4'd2;
    localparam logic [3:0] CMD_SCL_LABEL  = 4'd3;
    localparam logic [3:0] CMD_SCL_FEAT   = 4'd4;
    localparam logic [3:0] CMD_SCL_END    = 4'd5;
    localparam logic [3:0] CMD_LOAD_FEAT  = 4'd6;
    localparam logic [3:0] CMD_LOAD_LABEL = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    localparam logic [2:0] REG_RANGE_LOWER = 3'd0;
    localparam logic [2:0] REG_RANGE_UPPER = 3'd1;
    localparam logic [2:0] REG_LABEL_LOWER = 3'd2;
    localparam logic [2:0] REG_LABEL_UPPER = 3'd3;
    localparam logic [2:0] REG_LABEL_SCALE = 3'd4;
    localparam logic [2:0] REG_FEAT_IN_USE = 3'd5;

    localparam logic [1:0] KIND_FEATURE = 2'd0;
    localparam logic [1:0] KIND_LABEL   = 2'd1;
    localparam logic [1:0] KIND_ROW_END = 2'd2;

    typedef enum logic [3:0] {
        OP_OBS_LABEL,
        OP_OBS_FEAT,
        OP_OBS_END,
        OP_SCL_LABEL,
        OP_SCL_FEAT,
        OP_SCL_END,
        OP_LOAD_FEAT,
        OP_LOAD_LABEL,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] vmax;
    } entry_t;

    typedef struct packed {
        logic signed [31:0] range_lower;
        logic signed [31:0] range_upper;
        logic signed [31:0] label_lower;
        logic signed [31:0] label_upper;
        logic               label_scaling_on;
        logic [5:0]         limit;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/sfms_if.sv]
`default_nettype none

interface sfms_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic [5:0]         feature_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] range_max;

    modport source (output valid, command, feature_index, sample_value, range_max,
                    input ready);
    modport sink (input valid, command, feature_index, sample_value, range_max,
                  output ready);
endinterface

interface sfms_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         item_kind;
    logic [5:0]         out_index;
    logic signed [31:0] scaled_value;
    logic               last;

    modport source (output valid, item_kind, out_index, scaled_value, last,
                    input ready);
    modport sink (input valid, item_kind, out_index, scaled_value, last,
                  output ready);
endinterface

`default_nettype wire

[hdl/sfms_front.sv]
`default_nettype none

module sfms_front
    import sfms_pkg::*;
#(
    parameter int MAX_FEATURES = 63
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    sfms_in_if.sink          sample_ch,
    input  wire logic        q_full,
    output logic             q_push,
    output entry_t           q_entry,
    output cfg_t             cfg
);

    localparam logic [5:0] MAXF = 6'(MAX_FEATURES);

    logic signed [31:0] range_lower_reg;
    logic signed [31:0] range_upper_reg;
    logic signed [31:0] label_lower_reg;
    logic signed [31:0] label_upper_reg;
    logic               label_scale_reg;
    logic [5:0]         feat_in_use_reg;
    logic [5:0]         limit;
    logic               k_ok;
    logic               keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lower_reg <= 32'sd0;
            range_upper_reg <= 32'sd65536;
            label_lower_reg <= 32'sd0;
            label_upper_reg <= 32'sd65536;
            label_scale_reg <= 1'b0;
            feat_in_use_reg <= 6'd63;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOWER: range_lower_reg <= cfg_data;
                REG_RANGE_UPPER: range_upper_reg <= cfg_data;
                REG_LABEL_LOWER: label_lower_reg <= cfg_data;
                REG_LABEL_UPPER: label_upper_reg <= cfg_data;
                REG_LABEL_SCALE: label_scale_reg <= cfg_data[0];
                REG_FEAT_IN_USE: feat_in_use_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign limit = (feat_in_use_reg < MAXF) ? feat_in_use_reg : MAXF;
    assign k_ok  = (sample_ch.feature_index != 6'd0) && (sample_ch.feature_index <= limit);

    always_comb
    begin
        keep       = 1'b1;
        q_entry.op = OP_CLEAR;
        case (sample_ch.command)
            CMD_OBS_LABEL:  q_entry.op = OP_OBS_LABEL;
            CMD_OBS_FEAT:
            begin
                q_entry.op = OP_OBS_FEAT;
                keep       = k_ok;
            end
            CMD_OBS_END:    q_entry.op = OP_OBS_END;
            CMD_SCL_LABEL:  q_entry.op = OP_SCL_LABEL;
            CMD_SCL_FEAT:
            begin
                q_entry.op = OP_SCL_FEAT;
                keep       = k_ok;
            end
            CMD_SCL_END:    q_entry.op = OP_SCL_END;
            CMD_LOAD_FEAT:
            begin
                q_entry.op = OP_LOAD_FEAT;
                keep       = k_ok;
            end
            CMD_LOAD_LABEL: q_entry.op = OP_LOAD_LABEL;
            CMD_CLEAR:      q_entry.op = OP_CLEAR;
            default:        keep = 1'b0;
        endcase
    end

    assign q_entry.idx  = sample_ch.feature_index;
    assign q_entry.val  = sample_ch.sample_value;
    assign q_entry.vmax = sample_ch.range_max;

    assign sample_ch.ready = !q_full;
    assign q_push          = sample_ch.valid && !q_full && keep;

    assign cfg.range_lower      = range_lower_reg;
    assign cfg.range_upper      = range_upper_reg;
    assign cfg.label_lower      = label_lower_reg;
    assign cfg.label_upper      = label_upper_reg;
    assign cfg.label_scaling_on = label_scale_reg;
    assign cfg.limit            = limit;

endmodule

`default_nettype wire

[hdl/sfms_queue.sv]
`default_nettype none

module sfms_queue
    import sfms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  entry_t    push_entry,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output entry_t    head
);

    entry_t     slot_reg [0:1];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rptr_reg];

endmodule

`default_nettype wire

[hdl/sfms_div.sv]
`default_nettype none

module sfms_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);

    logic [63:0] dq_reg;
    logic [31:0] rem_reg;
    logic [31:0] d_reg;
    logic [6:0]  count_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, dq_reg[63]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= 32'd0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
            dq_reg  <= {dq_reg[62:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 7'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= 7'd64;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 7'd1;
            if (count_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

[hdl/sfms_back.sv]
`default_nettype none

module sfms_back
    import sfms_pkg::*;
#(
    parameter int MAX_FEATURES = 63
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic q_valid,
    input  entry_t    q_entry,
    output logic      q_pop,
    sfms_out_if.source result_ch
);

    localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES + 1) : 1;
    localparam logic [40:0] QCAP = 41'h100_0000_0000;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_READ = 13'b0000000000010,
        S_EVAL = 13'b0000000000100,
        S_CALC = 13'b0000000001000,
        S_MUL  = 13'b0000000010000,
        S_DIVS = 13'b0000000100000,
        S_DIV  = 13'b0000001000000,
        S_FIN  = 13'b0000010000000,
        S_RES  = 13'b0000100000000,
        S_PUSH = 13'b0001000000000,
        S_NEXT = 13'b0010000000000,
        S_MARK = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t             state_reg;
    entry_t             item_reg;
    logic [6:0]         nei_reg;
    logic [5:0]         cur_reg;
    logic [5:0]         end_reg;
    logic               single_reg;
    logic               is_label_reg;

    logic [63:0]        tab_mem [0:MAX_FEATURES];
    logic [MAX_FEATURES:0] tab_valid_reg;
    logic [63:0]        rd_reg;
    logic signed [31:0] label_min_reg;
    logic signed [31:0] label_max_reg;

    logic signed [31:0] c_lower_reg;
    logic signed [31:0] c_upper_reg;
    logic signed [31:0] c_mn_reg;
    logic signed [31:0] c_mx_reg;
    logic signed [31:0] c_val_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        d_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic signed [31:0] s_reg;

    logic [1:0]         res_kind_reg;
    logic [5:0]         res_idx_reg;
    logic signed [31:0] res_val_reg;
    logic               pend_valid_reg;
    logic [1:0]         pend_kind_reg;
    logic [5:0]         pend_idx_reg;
    logic signed [31:0] pend_val_reg;
    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [5:0]         out_idx_reg;
    logic signed [31:0] out_val_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               is_feat;
    logic signed [31:0] rd_mn;
    logic signed [31:0] rd_mx;
    logic signed [31:0] cur_val;
    logic signed [32:0] n1;
    logic signed [32:0] n2;
    logic signed [32:0] dd;
    logic [32:0]        n1_abs;
    logic [32:0]        n2_abs;
    logic [32:0]        dd_abs;
    logic [63:0]        div_q;
    logic               div_busy;
    logic [40:0]        q_cap;
    logic signed [41:0] sum;
    logic signed [31:0] sat;
    logic               tab_we;
    logic [IW-1:0]      tab_waddr;
    logic [63:0]        tab_wdata;

    assign out_free = !out_valid_reg || result_ch.ready;
    assign is_feat  = (item_reg.op == OP_OBS_FEAT) || (item_reg.op == OP_SCL_FEAT);
    assign rd_mn    = tab_valid_reg[cur_reg[IW-1:0]] ? rd_reg[63:32] : POS_MAX;
    assign rd_mx    = tab_valid_reg[cur_reg[IW-1:0]] ? rd_reg[31:0] : NEG_MIN;
    assign cur_val  = (is_feat && cur_reg == end_reg) ? item_reg.val : 32'sd0;

    assign n1     = 33'(c_upper_reg) - 33'(c_lower_reg);
    assign n2     = 33'(c_val_reg) - 33'(c_mn_reg);
    assign dd     = 33'(c_mx_reg) - 33'(c_mn_reg);
    assign n1_abs = n1[32] ? 33'(-n1) : 33'(n1);
    assign n2_abs = n2[32] ? 33'(-n2) : 33'(n2);
    assign dd_abs = dd[32] ? 33'(-dd) : 33'(dd);

    assign q_cap = (div_q > 64'(QCAP)) ? QCAP : div_q[40:0];
    assign sum   = neg_reg ? (42'(c_lower_reg) - $signed({1'b0, q_cap}))
                           : (42'(c_lower_reg) + $signed({1'b0, q_cap}));
    assign sat   = (sum > 42'(POS_MAX)) ? POS_MAX :
                   (sum < 42'(NEG_MIN)) ? NEG_MIN : sum[31:0];

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    sfms_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVS),
        .dividend (prod_reg),
        .divisor  (d_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        tab_we    = 1'b0;
        tab_waddr = cur_reg[IW-1:0];
        tab_wdata = {(cur_val < rd_mn) ? cur_val : rd_mn,
                     (cur_val > rd_mx) ? cur_val : rd_mx};
        if (state_reg == S_IDLE && q_valid && q_entry.op == OP_LOAD_FEAT)
        begin
            tab_we    = 1'b1;
            tab_waddr = q_entry.idx[IW-1:0];
            tab_wdata = {q_entry.val, q_entry.vmax};
        end
        else if (state_reg == S_EVAL && item_reg.op != OP_SCL_FEAT
                 && item_reg.op != OP_SCL_END)
        begin
            tab_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_reg <= tab_mem[cur_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= q_entry;
                if (q_entry.op == OP_SCL_LABEL)
                begin
                    c_lower_reg  <= cfg.label_lower;
                    c_upper_reg  <= cfg.label_upper;
                    c_mn_reg     <= label_min_reg;
                    c_mx_reg     <= label_max_reg;
                    c_val_reg    <= q_entry.val;
                    res_kind_reg <= KIND_LABEL;
                    res_idx_reg  <= 6'd0;
                    res_val_reg  <= q_entry.val;
                end
            end
            S_EVAL:
            begin
                c_lower_reg <= cfg.range_lower;
                c_upper_reg <= cfg.range_upper;
                c_mn_reg    <= rd_mn;
                c_mx_reg    <= rd_mx;
                c_val_reg   <= cur_val;
            end
            S_CALC:
            begin
                a_reg   <= n1_abs[31:0];
                b_reg   <= n2_abs[31:0];
                d_reg   <= dd_abs[31:0];
                neg_reg <= (n1[32] != n2[32]) != dd[32];
                if (c_val_reg == c_mn_reg || dd == 33'sd0)
                begin
                    s_reg <= c_lower_reg;
                end
                else
                begin
                    s_reg <= c_upper_reg;
                end
            end
            S_MUL:  prod_reg <= a_reg * b_reg;
            S_FIN:  s_reg <= sat;
            S_RES:
            begin
                res_kind_reg <= is_label_reg ? KIND_LABEL : KIND_FEATURE;
                res_idx_reg  <= is_label_reg ? 6'd0 : cur_reg;
                res_val_reg  <= s_reg;
            end
            S_MARK:
            begin
                res_kind_reg <= KIND_ROW_END;
                res_idx_reg  <= 6'd0;
                res_val_reg  <= 32'sd0;
            end
            default: ;
        endcase
        if (state_reg == S_PUSH && (!pend_valid_reg || out_free))
        begin
            pend_kind_reg <= res_kind_reg;
            pend_idx_reg  <= res_idx_reg;
            pend_val_reg  <= res_val_reg;
        end
        if (out_free && pend_valid_reg && (state_reg == S_PUSH || state_reg == S_DONE))
        begin
            out_kind_reg <= pend_kind_reg;
            out_idx_reg  <= pend_idx_reg;
            out_val_reg  <= pend_val_reg;
            out_last_reg <= state_reg == S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nei_reg        <= 7'd1;
            cur_reg        <= 6'd0;
            end_reg        <= 6'd0;
            single_reg     <= 1'b0;
            is_label_reg   <= 1'b0;
            tab_valid_reg  <= '0;
            label_min_reg  <= POS_MAX;
            label_max_reg  <= NEG_MIN;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (tab_we)
            begin
                tab_valid_reg[tab_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        single_reg   <= 1'b0;
                        is_label_reg <= 1'b0;
                        case (q_entry.op)
                            OP_OBS_LABEL:
                            begin
                                if (q_entry.val < label_min_reg)
                                begin
                                    label_min_reg <= q_entry.val;
                                end
                                if (q_entry.val > label_max_reg)
                                begin
                                    label_max_reg <= q_entry.val;
                                end
                                nei_reg <= 7'd1;
                            end
                            OP_SCL_LABEL:
                            begin
                                nei_reg      <= 7'd1;
                                single_reg   <= 1'b1;
                                is_label_reg <= 1'b1;
                                state_reg    <= cfg.label_scaling_on ? S_CALC : S_PUSH;
                            end
                            OP_OBS_FEAT, OP_SCL_FEAT:
                            begin
                                end_reg   <= q_entry.idx;
                                cur_reg   <= (nei_reg <= {1'b0, q_entry.idx})
                                             ? nei_reg[5:0] : q_entry.idx;
                                nei_reg   <= {1'b0, q_entry.idx} + 7'd1;
                                state_reg <= S_READ;
                            end
                            OP_OBS_END, OP_SCL_END:
                            begin
                                nei_reg <= 7'd1;
                                end_reg <= cfg.limit;
                                cur_reg <= nei_reg[5:0];
                                if (nei_reg <= {1'b0, cfg.limit})
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    state_reg <= (q_entry.op == OP_SCL_END) ? S_MARK : S_DONE;
                                end
                            end
                            OP_LOAD_LABEL:
                            begin
                                label_min_reg <= q_entry.val;
                                label_max_reg <= q_entry.vmax;
                            end
                            OP_CLEAR:
                            begin
                                tab_valid_reg <= '0;
                                label_min_reg <= POS_MAX;
                                label_max_reg <= NEG_MIN;
                                nei_reg       <= 7'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (item_reg.op == OP_SCL_FEAT || item_reg.op == OP_SCL_END)
                    begin
                        if (rd_mn == rd_mx || (rd_mn == POS_MAX && rd_mx == NEG_MIN))
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_CALC:
                begin
                    if (c_val_reg == c_mn_reg || c_val_reg == c_mx_reg || dd == 33'sd0)
                    begin
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:  state_reg <= S_DIVS;
                S_DIVS: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:  state_reg <= S_RES;
                S_RES:
                begin
                    if (!is_label_reg && s_reg == 32'sd0)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_valid_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        state_reg <= single_reg ? S_DONE : S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (cur_reg == end_reg)
                    begin
                        state_reg <= (item_reg.op == OP_SCL_END) ? S_MARK : S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= cur_reg + 6'd1;
                        state_reg <= S_READ;
                    end
                end
                S_MARK:
                begin
                    single_reg <= 1'b1;
                    state_reg  <= S_PUSH;
                end
                S_DONE:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.item_kind    = out_kind_reg;
    assign result_ch.out_index    = out_idx_reg;
    assign result_ch.scaled_value = out_val_reg;
    assign result_ch.last         = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("result left pending at item end");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVS |-> d_reg != 32'd0)
        else $error("divide started with zero divisor");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_EVAL) |-> cur_reg <= end_reg)
        else $error("table walk past its end");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != S_IDLE || !pend_valid_reg)
        else $error("queue popped while a result was pending");

endmodule

`default_nettype wire

[hdl/sparse_feature_minmax_scaler.sv]
// channel     dir   fields                                           request on
// sample_ch   in    command feature_index sample_value range_max     valid & ready
// result_ch   out   item_kind out_index scaled_value last            valid & ready
// cfg         in    cfg_index cfg_data                               cfg_we
//
// label observe, load and clear requests are finished in the back end's idle
// state; a feature walk takes each table entry through a registered table read,
// an update and a step; a scaled entry also passes the 64-step restoring divider
// reset clears the min/max table at once through per-entry valid bits
// a two-entry queue and the output register let either side stall alone

`default_nettype none

module sparse_feature_minmax_scaler
    import sfms_pkg::*;
#(
    parameter int MAX_FEATURES = 63
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    sfms_in_if.sink          sample_ch,
    sfms_out_if.source       result_ch
);

    cfg_t   cfg;
    entry_t push_entry;
    entry_t head;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;

    sfms_front #(.MAX_FEATURES(MAX_FEATURES)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .cfg       (cfg)
    );

    sfms_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (head)
    );

    sfms_back #(.MAX_FEATURES(MAX_FEATURES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_entry   (head),
        .q_pop     (q_pop),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

[tb/scaler_checker.sv]
`timescale 1ns / 100ps

module scaler_checker
    import sfms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    sfms_in_if          sample_ch,
    sfms_out_if         result_ch,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [1:0]         kind;
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } scaled_item_t;

    scaled_item_t       scaled_due[$];
    scaled_item_t       row_items[$];

    logic signed [31:0] feat_min [0:63];
    logic signed [31:0] feat_max [0:63];
    logic signed [31:0] lbl_min;
    logic signed [31:0] lbl_max;
    int                 next_idx;

    logic signed [31:0] rng_lo;
    logic signed [31:0] rng_hi;
    logic signed [31:0] lbl_lo;
    logic signed [31:0] lbl_hi;
    logic               lbl_scale_on;
    logic [5:0]         in_use;

    assign pending = scaled_due.size();

    function automatic logic signed [31:0] minmax_ratio(longint lower, longint upper,
                                                       longint mn, longint mx, longint v);
        longint       dd;
        longint       n1;
        longint       n2;
        longint       s;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] d;
        logic [127:0] q;
        bit           neg;
        if (v == mn)
            return 32'(lower);
        if (v == mx)
            return 32'(upper);
        dd = mx - mn;
        if (dd == 0)
            return 32'(lower);
        n1 = upper - lower;
        n2 = v - mn;
        neg = ((n1 < 0) != (n2 < 0)) != (dd < 0);
        a = (n1 < 0) ? -n1 : n1;
        b = (n2 < 0) ? -n2 : n2;
        d = (dd < 0) ? -dd : dd;
        q = (a * b) / d;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        s = neg ? lower - longint'(q[63:0]) : lower + longint'(q[63:0]);
        if (s > longint'(POS_MAX))
            s = POS_MAX;
        if (s < longint'(NEG_MIN))
            s = NEG_MIN;
        return s[31:0];
    endfunction

    function automatic void push_item(logic [1:0] kind, logic [5:0] idx, logic signed [31:0] val);
        scaled_item_t it;
        it.kind = kind;
        it.idx  = idx;
        it.val  = val;
        it.last = 1'b0;
        row_items.push_back(it);
    endfunction

    function automatic void touch_feature(int i, logic signed [31:0] v, bit scaling);
        logic signed [31:0] s;
        if (!scaling) begin
            if (v < feat_min[i])
                feat_min[i] = v;
            if (v > feat_max[i])
                feat_max[i] = v;
        end
        else if (!(feat_min[i] == feat_max[i] ||
                   (feat_min[i] == POS_MAX && feat_max[i] == NEG_MIN))) begin
            s = minmax_ratio(rng_lo, rng_hi, feat_min[i], feat_max[i], v);
            if (s != 0)
                push_item(KIND_FEATURE, 6'(i), s);
        end
    endfunction

    function automatic void fill_skipped(int upto, bit scaling);
        for (int i = next_idx; i < upto && i <= 63; i++)
            touch_feature(i, 0, scaling);
    endfunction

    function automatic void clear_ranges();
        for (int i = 0; i < 64; i++) begin
            feat_min[i] = POS_MAX;
            feat_max[i] = NEG_MIN;
        end
        lbl_min  = POS_MAX;
        lbl_max  = NEG_MIN;
        next_idx = 1;
    endfunction

    function automatic void predict_scaling(logic [3:0] cmd, logic [5:0] k,
                                            logic signed [31:0] v, logic signed [31:0] vmax);
        int lim;
        bit k_ok;
        lim  = (in_use < 63) ? in_use : 63;
        k_ok = (k >= 1 && k <= lim);
        row_items.delete();
        case (cmd)
            CMD_OBS_LABEL:
            begin
                if (v < lbl_min)
                    lbl_min = v;
                if (v > lbl_max)
                    lbl_max = v;
                next_idx = 1;
            end
            CMD_OBS_FEAT, CMD_SCL_FEAT:
            begin
                if (k_ok) begin
                    fill_skipped(k, cmd == CMD_SCL_FEAT);
                    touch_feature(k, v, cmd == CMD_SCL_FEAT);
                    next_idx = k + 1;
                end
            end
            CMD_OBS_END, CMD_SCL_END:
            begin
                fill_skipped(lim + 1, cmd == CMD_SCL_END);
                if (cmd == CMD_SCL_END)
                    push_item(KIND_ROW_END, 0, 0);
                next_idx = 1;
            end
            CMD_SCL_LABEL:
            begin
                push_item(KIND_LABEL, 0, lbl_scale_on ?
                          minmax_ratio(lbl_lo, lbl_hi, lbl_min, lbl_max, v) : v);
                next_idx = 1;
            end
            CMD_LOAD_FEAT:
            begin
                if (k_ok) begin
                    feat_min[k] = v;
                    feat_max[k] = vmax;
                end
            end
            CMD_LOAD_LABEL:
            begin
                lbl_min = v;
                lbl_max = vmax;
            end
            CMD_CLEAR:
                clear_ranges();
            default:
                ;
        endcase
        if (row_items.size() > 0)
            row_items[row_items.size() - 1].last = 1'b1;
        foreach (row_items[j])
            scaled_due.push_back(row_items[j]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_item_t want;
        if (!rst_n) begin
            rng_lo       = 0;
            rng_hi       = 65536;
            lbl_lo       = 0;
            lbl_hi       = 65536;
            lbl_scale_on = 1'b0;
            in_use       = 6'd63;
            clear_ranges();
            scaled_due.delete();
            fail_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RANGE_LOWER: rng_lo = cfg_data;
                    REG_RANGE_UPPER: rng_hi = cfg_data;
                    REG_LABEL_LOWER: lbl_lo = cfg_data;
                    REG_LABEL_UPPER: lbl_hi = cfg_data;
                    REG_LABEL_SCALE: lbl_scale_on = cfg_data[0];
                    REG_FEAT_IN_USE: in_use = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready) begin
                if (scaled_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result kind %0d idx %0d val %0d last %0b",
                             $time, result_ch.item_kind, result_ch.out_index,
                             result_ch.scaled_value, result_ch.last);
                end
                else begin
                    want = scaled_due.pop_front();
                    if (want.kind != result_ch.item_kind || want.idx != result_ch.out_index ||
                        want.val != result_ch.scaled_value || want.last != result_ch.last) begin
                        fail_count++;
                        $display("%0t: expected kind %0d idx %0d val %0d last %0b, got %0d %0d %0d %0b",
                                 $time, want.kind, want.idx, want.val, want.last,
                                 result_ch.item_kind, result_ch.out_index,
                                 result_ch.scaled_value, result_ch.last);
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                predict_scaling(sample_ch.command, sample_ch.feature_index,
                                sample_ch.sample_value, sample_ch.range_max);
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import sfms_pkg::*;

    localparam int DRAIN_CYCLES = 15000;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 10000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          sent;
    int          cycles;
    int          lim;
    bit          quiet;
    bit          hold_go;

    sfms_in_if  sample_ch();
    sfms_out_if result_ch();

    sparse_feature_minmax_scaler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    scaler_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return POS_MAX;
            1: return NEG_MIN;
            2: return 0;
            3: return $urandom();
            4: return (int'($urandom_range(0, 8)) - 4) <<< 16;
            default: return int'($urandom_range(0, 400000)) - 200000;
        endcase
    endfunction

    task automatic send_request(logic [3:0] cmd, logic [5:0] k,
                                logic signed [31:0] v, logic signed [31:0] vmax);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.command       <= cmd;
        sample_ch.feature_index <= k;
        sample_ch.sample_value  <= v;
        sample_ch.range_max     <= vmax;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_ranges(logic [31:0] lo, logic [31:0] hi, logic [31:0] llo,
                              logic [31:0] lhi, logic lon, logic [5:0] use_n);
        settle();
        write_reg(REG_RANGE_LOWER, lo);
        write_reg(REG_RANGE_UPPER, hi);
        write_reg(REG_LABEL_LOWER, llo);
        write_reg(REG_LABEL_UPPER, lhi);
        write_reg(REG_LABEL_SCALE, {31'd0, lon});
        write_reg(REG_FEAT_IN_USE, {26'd0, use_n});
        lim = use_n;
    endtask

    task automatic send_row(bit scaling);
        int k;
        send_request(scaling ? CMD_SCL_LABEL : CMD_OBS_LABEL, 6'($urandom()), pick_value(),
                     $urandom());
        k = 0;
        while (k < lim)
        begin
            k = k + $urandom_range(1, 3);
            if (k <= lim)
                send_request(scaling ? CMD_SCL_FEAT : CMD_OBS_FEAT, 6'(k), pick_value(),
                             $urandom());
        end
        send_request(scaling ? CMD_SCL_END : CMD_OBS_END, 6'($urandom()), $urandom(),
                     $urandom());
    endtask

    task automatic send_noise();
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = pick_value();
        b = pick_value();
        case ($urandom_range(0, 3))
            0: send_request(4'($urandom()), 6'($urandom()), $urandom(), $urandom());
            1: send_request(CMD_LOAD_FEAT, 6'($urandom_range(0, 63)), (a < b) ? a : b,
                            (a < b) ? b : a);
            2: send_request(CMD_LOAD_LABEL, 0, a, b);
            default: send_request($urandom_range(0, 1) ? CMD_SCL_FEAT : CMD_OBS_FEAT,
                                  6'($urandom_range(0, 63)), a, b);
        endcase
    endtask

    task automatic run_rows(int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_row($urandom_range(0, 1));
            if ($urandom_range(0, 30) == 0)
                send_request(CMD_CLEAR, 0, 0, 0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sent      = 0;
        lim       = 63;
        quiet     = 1'b0;
        hold_go   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.command       = '0;
        sample_ch.feature_index = '0;
        sample_ch.sample_value  = '0;
        sample_ch.range_max     = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_request(CMD_OBS_LABEL, 0, NEG_MIN, 0);
        send_request(CMD_OBS_FEAT, 1, NEG_MIN, 0);
        send_request(CMD_OBS_FEAT, 0, 32'sd5, 0);
        send_request(CMD_OBS_FEAT, 63, POS_MAX, 0);
        send_request(CMD_OBS_END, 0, 0, 0);
        send_request(CMD_OBS_LABEL, 0, POS_MAX, 0);
        send_request(CMD_OBS_FEAT, 5, 32'sd65536, 0);
        send_request(CMD_OBS_END, 0, 0, 0);
        send_request(CMD_SCL_LABEL, 0, 32'sd12345, 0);
        send_request(CMD_SCL_FEAT, 1, NEG_MIN, 0);
        send_request(CMD_SCL_FEAT, 5, 32'sd32768, 0);
        send_request(CMD_SCL_FEAT, 3, -32'sd7, 0);
        send_request(CMD_SCL_FEAT, 63, POS_MAX, 0);
        send_request(CMD_SCL_END, 0, 0, 0);
        send_request(CMD_LOAD_FEAT, 2, 32'sd100, 32'sd100);
        send_request(CMD_LOAD_FEAT, 4, 0, 32'sd65536);
        send_request(CMD_LOAD_LABEL, 0, 32'sd65536, 32'sd65536);
        send_request(CMD_SCL_FEAT, 2, 32'sd100, 0);
        send_request(CMD_SCL_FEAT, 4, 32'sd65536, 0);
        send_request(4'($urandom_range(9, 15)), 4, 0, 0);
        send_request(CMD_SCL_END, 0, 0, 0);
        send_request(CMD_CLEAR, 0, 0, 0);
        send_request(CMD_SCL_FEAT, 7, 32'sd3, 0);
        send_request(CMD_SCL_END, 0, 0, 0);

        set_ranges(NEG_MIN, POS_MAX, POS_MAX, NEG_MIN, 1'b1, 6'd8);
        send_request(CMD_SCL_LABEL, 0, 32'sd9, 0);
        send_request(CMD_LOAD_LABEL, 0, 32'sd4, 32'sd4);
        send_request(CMD_SCL_LABEL, 0, 32'sd9, 0);
        run_rows(40);

        set_ranges(POS_MAX, NEG_MIN, 32'sd65536, -32'sd65536, 1'b1, 6'd1);
        run_rows(30);

        set_ranges(-32'sd65536, 32'sd65536, 0, 32'sd65536, 1'b0, 6'd63);
        send_row(1'b0);
        hold_go = 1'b1;
        send_row(1'b1);
        send_row(1'b1);

        set_ranges(0, 32'sd655360, NEG_MIN, POS_MAX, 1'b1, 6'd6);
        run_rows(40);

        set_ranges(0, 32'sd65536, 0, 32'sd65536, 1'b1, 6'd5);
        quiet = 1'b1;
        run_rows(30);

        settle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
